### src/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace unit
// Holds register indexes, result kinds and the controller/datapath links.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int PatMax   = 16;
  localparam int CntWidth = 32;
  localparam int HeldW    = 5;   // holds 0..PatMax
  localparam int IdxW     = 4;   // indexes 0..PatMax-1

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  typedef enum logic [2:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_PAT_LEN = 3'd2,
    REG_REP_LO  = 3'd3,
    REG_REP_HI  = 3'd4,
    REG_REP_LEN = 3'd5,
    REG_ICASE   = 3'd6,
    REG_RMODE   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_MATCH  = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  // datapath operations ordered by the controller
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PUSH    = 3'd1,  // append input byte to the hold buffer
    OP_RELEASE = 3'd2,  // drop front held byte, count it, maybe emit it
    OP_MATCH   = 3'd3,  // report match, start replacement
    OP_REP     = 3'd4,  // emit one replacement byte
    OP_CNTPAT  = 3'd5,  // count one matched byte in find mode
    OP_END     = 3'd6,  // end marker and restart
    OP_FINISH  = 3'd7   // clear hold after match
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            emit;   // push a result beat into the output register
    logic            last;
    logic            latch;  // capture the accepted input byte
    logic [IdxW-1:0] idx;    // replacement / matched byte index
  } cmd_t;

  typedef struct packed {
    logic [HeldW-1:0] held_count;
    logic             prefix_ok;       // held bytes form a pattern prefix
    logic             prefix_next_ok;  // held bytes after the front one do
    logic             first_ok;        // captured byte opens the pattern
    logic [HeldW-1:0] plen;
    logic [HeldW-1:0] rlen;
    logic             rmode;
    logic             out_busy;    // output register still full
  } stat_t;

  function automatic logic [CntWidth-1:0] sat_inc(input logic [CntWidth-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

### src/sfr_datapath.sv
// ---------------------------------------------------------------------------
// sfr_datapath: hold buffer, counters, configuration and output register
// Executes one controller command a cycle.
// ---------------------------------------------------------------------------
module sfr_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  input  logic [7:0]                  in_byte_i,
  input  sfr_pkg::cmd_t               cmd_i,
  output sfr_pkg::stat_t              stat_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  out_byte_o,
  output logic [31:0]                 line_number_o,
  output logic [31:0]                 match_offset_o,
  output logic                        last_o
);

  logic [63:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [4:0]  pat_len_q, rep_len_q;
  logic        icase_q, rmode_q;

  logic [7:0]  held_q [sfr_pkg::PatMax];
  logic [sfr_pkg::HeldW-1:0] held_cnt_q;
  logic [sfr_pkg::CntWidth-1:0] line_q, in_pos_q, out_pos_q;
  logic        prev_cr_q;
  logic [7:0]  in_q;
  logic [7:0]  push_b;

  logic [127:0] pat_w, rep_w;
  assign pat_w = {pat_hi_q, pat_lo_q};
  assign rep_w = {rep_hi_q, rep_lo_q};

  // the accepted byte is used directly, later from the capture register
  assign push_b = cmd_i.latch ? in_byte_i : in_q;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
    return (ic && b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  logic [sfr_pkg::HeldW-1:0] plen, rlen;
  always_comb begin
    plen = (pat_len_q == '0) ? 5'd1 : (pat_len_q > 5'd16 ? 5'd16 : pat_len_q);
    rlen = (rep_len_q > 5'd16) ? 5'd16 : rep_len_q;
  end

  // per-entry compare, independent lanes
  logic prefix_ok;
  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < sfr_pkg::PatMax; i++) begin
      if (5'(i) < held_cnt_q &&
          fold(held_q[i], icase_q) != fold(pat_w[i*8 +: 8], icase_q))
        prefix_ok = 1'b0;
    end
  end

  // same compare one entry on, as it stands once the front byte leaves
  logic prefix_next_ok;
  always_comb begin
    prefix_next_ok = 1'b1;
    for (int i = 0; i < sfr_pkg::PatMax - 1; i++) begin
      if (5'(i + 1) < held_cnt_q &&
          fold(held_q[i+1], icase_q) != fold(pat_w[i*8 +: 8], icase_q))
        prefix_next_ok = 1'b0;
    end
  end

  logic first_ok;
  assign first_ok = (fold(in_q, icase_q) == fold(pat_w[7:0], icase_q));

  logic out_busy;
  assign out_busy = out_valid_o && out_stall_i;

  assign stat_o = '{held_count: held_cnt_q, prefix_ok: prefix_ok,
                    prefix_next_ok: prefix_next_ok, first_ok: first_ok, plen: plen,
                    rlen: rlen, rmode: rmode_q, out_busy: out_busy};

  // line accounting for byte b
  logic [7:0] acc_b;
  logic       acc_en;
  logic [sfr_pkg::CntWidth-1:0] line_d;
  logic       prev_cr_d;
  always_comb begin
    line_d    = line_q;
    prev_cr_d = prev_cr_q;
    if (cmd_i.op == sfr_pkg::OP_END) begin
      line_d    = sfr_pkg::CntWidth'(1);
      prev_cr_d = 1'b0;
    end else if (acc_en) begin
      if (acc_b == sfr_pkg::ChLf) begin
        if (!prev_cr_q) line_d = sfr_pkg::sat_inc(line_q);
        prev_cr_d = 1'b0;
      end else if (acc_b == sfr_pkg::ChCr) begin
        line_d = sfr_pkg::sat_inc(line_q);
        prev_cr_d = 1'b1;
      end else begin
        prev_cr_d = 1'b0;
      end
    end
  end

  logic [7:0] rep_b;
  assign rep_b = rep_w[cmd_i.idx*8 +: 8];

  always_comb begin
    acc_en = 1'b0;
    acc_b  = held_q[0];
    case (cmd_i.op)
      sfr_pkg::OP_RELEASE: acc_en = 1'b1;
      sfr_pkg::OP_REP:     begin acc_en = 1'b1; acc_b = rep_b; end
      sfr_pkg::OP_CNTPAT:  begin acc_en = 1'b1; acc_b = held_q[cmd_i.idx]; end
      default: ;
    endcase
  end

  // saturating add of plen to the input position for the match
  logic [sfr_pkg::CntWidth:0] pos_sum;
  assign pos_sum = {1'b0, in_pos_q} + {{(sfr_pkg::CntWidth+1-5){1'b0}}, plen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0; pat_hi_q <= '0; rep_lo_q <= '0; rep_hi_q <= '0;
      pat_len_q <= 5'd1; rep_len_q <= '0; icase_q <= 1'b0; rmode_q <= 1'b0;
      held_cnt_q <= '0;
      line_q <= sfr_pkg::CntWidth'(1);
      prev_cr_q <= 1'b0;
      in_pos_q <= '0;
      out_pos_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (sfr_pkg::reg_idx_e'(cfg_index_i))
          sfr_pkg::REG_PAT_LO:  pat_lo_q  <= cfg_data_i;
          sfr_pkg::REG_PAT_HI:  pat_hi_q  <= cfg_data_i;
          sfr_pkg::REG_PAT_LEN: pat_len_q <= cfg_data_i[4:0];
          sfr_pkg::REG_REP_LO:  rep_lo_q  <= cfg_data_i;
          sfr_pkg::REG_REP_HI:  rep_hi_q  <= cfg_data_i;
          sfr_pkg::REG_REP_LEN: rep_len_q <= cfg_data_i[4:0];
          sfr_pkg::REG_ICASE:   icase_q   <= cfg_data_i[0];
          sfr_pkg::REG_RMODE:   rmode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      out_valid_o <= cmd_i.emit || (out_valid_o && out_stall_i);
      line_q    <= line_d;
      prev_cr_q <= prev_cr_d;
      case (cmd_i.op)
        sfr_pkg::OP_PUSH: held_cnt_q <= held_cnt_q + 1'b1;
        sfr_pkg::OP_RELEASE: begin
          held_cnt_q <= held_cnt_q - 1'b1;
          in_pos_q <= sfr_pkg::sat_inc(in_pos_q);
          if (rmode_q) out_pos_q <= sfr_pkg::sat_inc(out_pos_q);
        end
        sfr_pkg::OP_MATCH:
          in_pos_q <= pos_sum[sfr_pkg::CntWidth] ? '1 : pos_sum[sfr_pkg::CntWidth-1:0];
        sfr_pkg::OP_REP: out_pos_q <= sfr_pkg::sat_inc(out_pos_q);
        sfr_pkg::OP_FINISH: held_cnt_q <= '0;
        sfr_pkg::OP_END: begin
          held_cnt_q <= '0;
          in_pos_q <= '0;
          out_pos_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // hold buffer and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) in_q <= in_byte_i;
    case (cmd_i.op)
      sfr_pkg::OP_PUSH: held_q[held_cnt_q[sfr_pkg::IdxW-1:0]] <= push_b;
      sfr_pkg::OP_RELEASE:
        for (int i = 0; i < sfr_pkg::PatMax - 1; i++) held_q[i] <= held_q[i+1];
      default: ;
    endcase
    if (cmd_i.emit) begin
      last_o <= cmd_i.last;
      case (cmd_i.op)
        sfr_pkg::OP_RELEASE, sfr_pkg::OP_REP: begin
          kind_o <= sfr_pkg::KIND_BYTE;
          out_byte_o <= (cmd_i.op == sfr_pkg::OP_REP) ? rep_b : held_q[0];
          line_number_o <= '0;
          match_offset_o <= '0;
        end
        sfr_pkg::OP_MATCH: begin
          kind_o <= sfr_pkg::KIND_MATCH;
          out_byte_o <= '0;
          line_number_o <= line_q[31:0];
          match_offset_o <= rmode_q ? out_pos_q[31:0] : in_pos_q[31:0];
        end
        default: begin
          kind_o <= sfr_pkg::KIND_END;
          out_byte_o <= '0;
          line_number_o <= line_q[31:0];
          match_offset_o <= rmode_q ? out_pos_q[31:0] : in_pos_q[31:0];
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= 5'd16) else $error("hold count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_busy) else $error("beat overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == sfr_pkg::OP_RELEASE |-> held_cnt_q != '0) else $error("release empty");

endmodule

### src/sfr_ctrl.sv
// ---------------------------------------------------------------------------
// sfr_ctrl: sequencer for the stream find/replace unit
// Walks one input item through push, release, match, replacement, counting and end steps.
// ---------------------------------------------------------------------------
module sfr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           eos_i,
  input  sfr_pkg::stat_t stat_i,
  output sfr_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREFLUSH, ST_SCAN, ST_REP, ST_CNT, ST_FIN, ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic [sfr_pkg::IdxW-1:0] idx_q, idx_d;
  logic in_take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cmd_o = '{op: sfr_pkg::OP_NONE, emit: 1'b0, last: 1'b0, latch: 1'b0, idx: idx_q};
    case (state_q)
      ST_IDLE: if (in_take) begin
        cmd_o.latch = 1'b1;
        state_d = eos_i ? ST_FLUSH :
                  (stat_i.held_count >= stat_i.plen ? ST_PREFLUSH : ST_SCAN);
        if (!eos_i && stat_i.held_count < stat_i.plen) cmd_o.op = sfr_pkg::OP_PUSH;
      end
      ST_PREFLUSH: if (!stat_i.out_busy || !stat_i.rmode) begin
        if (stat_i.held_count != '0) begin
          cmd_o.op = sfr_pkg::OP_RELEASE;
          cmd_o.emit = stat_i.rmode;
          // final beat when the new byte then waits as a bare prefix
          cmd_o.last = (stat_i.held_count == 5'd1) && stat_i.first_ok &&
                       (stat_i.plen != 5'd1);
        end else begin
          cmd_o.op = sfr_pkg::OP_PUSH;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.held_count == stat_i.plen && stat_i.prefix_ok) begin
          if (!stat_i.out_busy) begin
            cmd_o.op = sfr_pkg::OP_MATCH;
            cmd_o.emit = 1'b1;
            idx_d = '0;
            if (stat_i.rmode && stat_i.rlen != '0) state_d = ST_REP;
            else if (stat_i.rmode) begin
              cmd_o.last = 1'b1;
              state_d = ST_CNT;  // finish with no counting
            end else begin
              cmd_o.last = 1'b1;
              state_d = ST_CNT;
            end
          end
        end else if (!stat_i.prefix_ok && stat_i.held_count != '0) begin
          if (!stat_i.out_busy || !stat_i.rmode) begin
            cmd_o.op = sfr_pkg::OP_RELEASE;
            cmd_o.emit = stat_i.rmode;
            cmd_o.last = stat_i.prefix_next_ok;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REP: if (!stat_i.out_busy) begin
        cmd_o.op = sfr_pkg::OP_REP;
        cmd_o.emit = 1'b1;
        cmd_o.last = ({1'b0, idx_q} == stat_i.rlen - 1'b1);
        if (cmd_o.last) begin
          state_d = ST_CNT;
          idx_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      ST_CNT: begin
        if (!stat_i.rmode) begin
          cmd_o.op = sfr_pkg::OP_CNTPAT;
          if ({1'b0, idx_q} == stat_i.plen - 1'b1) begin
            idx_d = '0;
            state_d = ST_FIN;
          end else idx_d = idx_q + 1'b1;
        end else begin
          cmd_o.op = sfr_pkg::OP_FINISH;
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        cmd_o.op = sfr_pkg::OP_FINISH;
        state_d = ST_IDLE;
      end
      ST_FLUSH: if (!stat_i.out_busy || !stat_i.rmode) begin
        if (stat_i.held_count != '0) begin
          cmd_o.op = sfr_pkg::OP_RELEASE;
          cmd_o.emit = stat_i.rmode;
        end else if (!stat_i.out_busy) begin
          cmd_o.op = sfr_pkg::OP_END;
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == sfr_pkg::OP_PUSH |-> stat_i.held_count < stat_i.plen)
    else $error("push into full hold");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REP |-> stat_i.rmode) else $error("replacement in find mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == sfr_pkg::OP_END |=> stat_i.held_count == '0)
    else $error("hold not cleared at end");

endmodule

### src/stream_find_replace_unit.sv
// ---------------------------------------------------------------------------
// stream_find_replace_unit: streaming literal find and replace
// One byte per item; match reports, rewritten bytes in replace mode and an end marker out.
// ---------------------------------------------------------------------------
// Each byte is taken in, then released held bytes, a match report and the
// replacement bytes follow in turn; in find mode each matched byte then
// updates the line counts, and a closing step clears the hold. A byte
// arriving after the pattern was shrunk first flushes the held bytes and is
// then stored. End of stream is taken in, flushes the held bytes and then
// gives the end marker.
// The output register holds one beat, so a stalled output holds the sequencer whenever it has a beat to give.
// The last flag marks the final beat of every item that gives results.
module stream_find_replace_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] line_number_o,
  output logic [31:0] match_offset_o,
  output logic        last_o
);

  sfr_pkg::cmd_t  cmd;
  sfr_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .eos_i(end_of_stream_i), .stat_i(stat), .cmd_o(cmd)
  );

  sfr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_byte_i(data_byte_i), .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_stall_i, .kind_o, .out_byte_o,
    .line_number_o, .match_offset_o, .last_o
  );

endmodule
